[rtl/core/amcp_pkg.sv]
// amcp_pkg: shared constants, types and the digit conversion for the
// ascii motor command parser; no dependencies
`default_nettype none

package amcp_pkg;

	localparam int LINE_LEN = 14;
	localparam int POS_W    = 4;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] DIGIT_BASE   = 8'd48;
	localparam logic [7:0] CHAR_PLUS    = 8'h2b;
	localparam logic [7:0] CHAR_MINUS   = 8'h2d;
	localparam logic [7:0] CHAR_P       = 8'h50;

	localparam logic [POS_W-1:0] POS_FULL     = POS_W'(LINE_LEN);
	localparam int               SIGN_A_POS   = 0;
	localparam int               SIGN_B_POS   = 5;
	localparam int               PRESCALE_POS = 10;

	localparam logic [15:0] PRESCALE_RESET = 16'd719;

	localparam int DUTY_W = 15;
	localparam int RES_W  = 2 * (DUTY_W + 2) + 16;
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

	typedef logic [LINE_LEN-1:0][7:0] line_t;

	// one received byte moving into the line store
	typedef struct packed {
		logic       en;
		logic [7:0] data;
	} line_wr_t;

	// drive state, first output field in the lowest bits
	typedef struct packed {
		logic [15:0]       pwm_prescale;
		logic [DUTY_W-1:0] duty_b;
		logic              rev_b;
		logic              fwd_b;
		logic [DUTY_W-1:0] duty_a;
		logic              rev_a;
		logic              fwd_a;
	} drive_t;

	// (b0-48)*100 + (b1-48)*10 + (b2-48), no digit check
	function automatic logic signed [15:0] three_digits(logic [7:0] b0, logic [7:0] b1,
			logic [7:0] b2);
		logic signed [15:0] d0;
		logic signed [15:0] d1;
		logic signed [15:0] d2;
		d0 = $signed({8'd0, b0}) - $signed({8'd0, DIGIT_BASE});
		d1 = $signed({8'd0, b1}) - $signed({8'd0, DIGIT_BASE});
		d2 = $signed({8'd0, b2}) - $signed({8'd0, DIGIT_BASE});
		return (d0 * 16'sd100) + (d1 * 16'sd10) + d2;
	endfunction

endpackage

`default_nettype wire

[rtl/core/ascii_motor_command_parser.sv]
// ascii_motor_command_parser: an accepted byte beat goes through the input
// register, then the result register, to its result beat; one byte beat per
// cycle sustained while m_axis_tready allows, the line decode being a single
// pass of constant-weight adds. arst_n clears the line store, position and
// setpoints, sets the prescaler to 719 and empties both registers.
// depends on amcp_pkg, amcp_line_store, amcp_cmd_decode
`default_nettype none

module ascii_motor_command_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // rx_byte
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// fwd_a, rev_a, duty_a, fwd_b, rev_b, duty_b, pwm_prescale, zero fill
	output logic [amcp_pkg::TDATA_W-1:0]       m_axis_tdata,
	output logic                               m_axis_tlast   // line_done
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                valid_s2;
	amcp_pkg::drive_t    drive_s2;
	logic                done_s2;
	logic                advance;
	amcp_pkg::line_wr_t  wr;
	amcp_pkg::line_t     line_view;
	amcp_pkg::drive_t    drive_d;
	logic                done_d;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign wr.en   = advance;
	assign wr.data = byte_s1;

	amcp_line_store u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.line_view (line_view)
	);

	amcp_cmd_decode u_cmd_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.line_view (line_view),
		.drive     (drive_d),
		.done      (done_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s2 <= drive_d;
			done_s2  <= done_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(amcp_pkg::TDATA_W - amcp_pkg::RES_W){1'b0}}, drive_s2};
	assign m_axis_tlast  = done_s2;

	a_dir_a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(drive_s2.fwd_a && drive_s2.rev_a) &&
			!(drive_s2.fwd_b && drive_s2.rev_b))
		else $error("forward and reverse both driven");

	a_idle_duty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !drive_s2.fwd_a && !drive_s2.rev_a |-> drive_s2.duty_a == '0)
		else $error("duty on motor a with no direction");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (!valid_s2 || m_axis_tready) |=> valid_s2)
		else $error("byte in input register did not reach result register");

endmodule

`default_nettype wire

[rtl/core/amcp_line_store.sv]
// amcp_line_store: 14-byte line buffer and line position
// depends on amcp_pkg
`default_nettype none

module amcp_line_store (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire amcp_pkg::line_wr_t wr,
	output amcp_pkg::line_t       line_view
);

	amcp_pkg::line_t                  store_q;
	logic [amcp_pkg::POS_W-1:0]       pos_q;
	logic                             room;
	logic                             newline;

	assign room    = pos_q < amcp_pkg::POS_FULL;
	assign newline = wr.data == amcp_pkg::NEWLINE_CODE;

	// store contents including the byte of this beat, if the line has room
	always_comb begin
		line_view = store_q;
		if (wr.en && room) begin
			line_view[pos_q] = wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			pos_q   <= '0;
		end else if (wr.en) begin
			store_q <= line_view;
			if (newline) begin
				pos_q <= '0;
			end else if (room) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= amcp_pkg::POS_FULL)
		else $error("line position beyond store");

	a_newline_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en && newline |=> pos_q == '0)
		else $error("newline did not rewind line position");

endmodule

`default_nettype wire

[rtl/core/amcp_cmd_decode.sv]
// amcp_cmd_decode: setpoint and prescaler registers, line decode and drive state
// depends on amcp_pkg
`default_nettype none

module amcp_cmd_decode (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire amcp_pkg::line_wr_t wr,
	input  wire amcp_pkg::line_t  line_view,
	output amcp_pkg::drive_t      drive,
	output logic                  done
);

	logic signed [15:0] setpoint_a_q;
	logic signed [15:0] setpoint_b_q;
	logic [15:0]        prescale_q;
	logic signed [15:0] setpoint_a_d;
	logic signed [15:0] setpoint_b_d;
	logic [15:0]        prescale_d;
	logic signed [15:0] num_a;
	logic signed [15:0] num_b;
	logic signed [15:0] num_p;
	logic signed [15:0] mag_a;
	logic signed [15:0] mag_b;

	assign done = wr.en && (wr.data == amcp_pkg::NEWLINE_CODE);

	assign num_a = amcp_pkg::three_digits(line_view[amcp_pkg::SIGN_A_POS + 1],
		line_view[amcp_pkg::SIGN_A_POS + 2], line_view[amcp_pkg::SIGN_A_POS + 3]);
	assign num_b = amcp_pkg::three_digits(line_view[amcp_pkg::SIGN_B_POS + 1],
		line_view[amcp_pkg::SIGN_B_POS + 2], line_view[amcp_pkg::SIGN_B_POS + 3]);
	assign num_p = amcp_pkg::three_digits(line_view[amcp_pkg::PRESCALE_POS + 1],
		line_view[amcp_pkg::PRESCALE_POS + 2], line_view[amcp_pkg::PRESCALE_POS + 3]);

	always_comb begin
		setpoint_a_d = setpoint_a_q;
		setpoint_b_d = setpoint_b_q;
		prescale_d   = prescale_q;
		if (done) begin
			if (line_view[amcp_pkg::SIGN_A_POS] == amcp_pkg::CHAR_PLUS) begin
				setpoint_a_d = num_a;
			end else if (line_view[amcp_pkg::SIGN_A_POS] == amcp_pkg::CHAR_MINUS) begin
				setpoint_a_d = -num_a;
			end
			if (line_view[amcp_pkg::SIGN_B_POS] == amcp_pkg::CHAR_PLUS) begin
				setpoint_b_d = num_b;
			end else if (line_view[amcp_pkg::SIGN_B_POS] == amcp_pkg::CHAR_MINUS) begin
				setpoint_b_d = -num_b;
			end
			if (line_view[amcp_pkg::PRESCALE_POS] == amcp_pkg::CHAR_P) begin
				// wraps to 16 bits
				prescale_d = num_p - 16'd1;
			end
		end
	end

	assign mag_a = setpoint_a_d[15] ? -setpoint_a_d : setpoint_a_d;
	assign mag_b = setpoint_b_d[15] ? -setpoint_b_d : setpoint_b_d;

	always_comb begin
		drive.fwd_a        = !setpoint_a_d[15] && (setpoint_a_d != '0);
		drive.rev_a        = setpoint_a_d[15];
		drive.duty_a       = mag_a[amcp_pkg::DUTY_W-1:0];
		drive.fwd_b        = !setpoint_b_d[15] && (setpoint_b_d != '0);
		drive.rev_b        = setpoint_b_d[15];
		drive.duty_b       = mag_b[amcp_pkg::DUTY_W-1:0];
		drive.pwm_prescale = prescale_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_a_q <= '0;
			setpoint_b_q <= '0;
			prescale_q   <= amcp_pkg::PRESCALE_RESET;
		end else if (wr.en) begin
			setpoint_a_q <= setpoint_a_d;
			setpoint_b_q <= setpoint_b_d;
			prescale_q   <= prescale_d;
		end
	end

	a_prescale_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> $stable(prescale_q))
		else $error("prescaler changed without a newline");

endmodule

`default_nettype wire
